[src/vfrg_pkg.sv]
// ----------------------------------------------------------------------------
// vfrg_pkg : shared types and constants of the V/f ramp generator
// Sequencer states, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vfrg_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREQ,
		ST_PMUL,
		ST_VSEL,
		ST_VMUL,
		ST_VDIV,
		ST_VOUT,
		ST_CINIT,
		ST_CORD,
		ST_DONE
	} state_t;

	localparam logic [2:0] REG_TARGET_FREQ  = 3'd0;
	localparam logic [2:0] REG_RAMP_STEP    = 3'd1;
	localparam logic [2:0] REG_NOMINAL_FREQ = 3'd2;
	localparam logic [2:0] REG_VOLT_MAX     = 3'd3;
	localparam logic [2:0] REG_VOLT_BOOST   = 3'd4;
	localparam logic [2:0] REG_PHASE_GAIN   = 3'd5;

	localparam int ATAN_ENTRIES = 24;
	// 1 / 1.64676 with 16 fraction bits
	localparam logic [15:0] CORDIC_SCALE = 16'd39797;

	typedef logic [29:0] atan_t [ATAN_ENTRIES];
	localparam atan_t ATAN_TABLE = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
		30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
	};

endpackage

[src/volts_per_hertz_ramp_generator_unit.sv]
// ----------------------------------------------------------------------------
// volts_per_hertz_ramp_generator_unit : scalar V/f drive reference
// Ramps frequency toward a target, derives voltage from the V/f line,
// advances the phase and rotates the voltage into d and q by CORDIC.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  input    | in        | in_valid / in_stall  | tick
//  output   | out       | out_valid / out_stall| out_freq out_voltage out_phase
//           |           |                      | out_d out_q
//  config   | in        | cfg_write            | cfg_index cfg_data
//
//  A tick runs the sequencer from idle through FREQ, PMUL, VSEL, VMUL, VDIV,
//  VOUT, CINIT, CORD (N CORDIC steps, N at most 24) and DONE back to idle;
//  the bit-serial multiplier (one multiplier bit a cycle) and the restoring
//  divider (one quotient bit a cycle) do the arithmetic. Above the knee or
//  at zero frequency the voltage multiply and divide are skipped. One tick
//  is in work at a time; the next transfer is taken while a finished result
//  waits on out_stall.
//  Reset clears frequency, phase and the sequencer.
// ----------------------------------------------------------------------------
module volts_per_hertz_ramp_generator_unit #(
	parameter int PHASE_BITS      = 32,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  tick,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [29:0]           out_freq,
	output logic [13:0]           out_voltage,
	output logic [31:0]           out_phase,
	output logic signed [14:0]    out_d,
	output logic signed [14:0]    out_q,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [39:0]           cfg_data
);

	localparam int NITER = (TRIG_ITERATIONS > vfrg_pkg::ATAN_ENTRIES) ?
		vfrg_pkg::ATAN_ENTRIES : TRIG_ITERATIONS;
	localparam logic [5:0] MUL_STEPS = 6'd30;
	localparam logic [5:0] DIV_STEPS = 6'd45;
	localparam logic [5:0] CORD_STEPS = 6'(NITER);

	vfrg_pkg::state_t state_q, state_d;

	logic [29:0] target_freq_q, ramp_step_q, nominal_freq_q;
	logic [13:0] volt_max_q, volt_boost_q;
	logic [39:0] phase_gain_q;

	logic [29:0]           freq_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [13:0]           volt_q;
	logic                  neg_q;
	logic [5:0]            cnt_q;

	logic [40:0] mul_hi_q;
	logic [29:0] mul_lo_q;
	logic [39:0] mcand_q;
	logic [40:0] mul_sum;
	logic [69:0] product;

	logic [44:0] dvd_q;
	logic [30:0] rem_q;
	logic [30:0] div_try;
	logic        div_ge;

	logic signed [33:0] x_q, y_q, xs, ys;
	logic signed [32:0] z_q;
	logic [1:0]         quad_q;
	logic [31:0]        ph32, ang;

	logic [29:0]        freq_next, diff;
	logic signed [14:0] slope;
	logic [13:0]        slope_mag;
	logic signed [17:0] xr, yr, cval, sval, vlim;
	logic [33:0]        x_init;

	logic in_xfer, out_xfer, out_load;

	assign in_stall = (state_q != vfrg_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign out_load = (state_q == vfrg_pkg::ST_DONE) && (!out_valid || !out_stall);

	// ramp toward the target, landing on it inside one step
	always_comb begin
		diff = (target_freq_q > freq_q) ? target_freq_q - freq_q : freq_q - target_freq_q;
		if (freq_q == target_freq_q || diff < ramp_step_q)
			freq_next = target_freq_q;
		else if (target_freq_q > freq_q)
			freq_next = freq_q + ramp_step_q;
		else
			freq_next = freq_q - ramp_step_q;
	end

	assign mul_sum = mul_hi_q + (mul_lo_q[0] ? {1'b0, mcand_q} : 41'd0);
	assign product = {mul_hi_q[39:0], mul_lo_q};

	assign div_try = {rem_q[29:0], dvd_q[44]};
	assign div_ge  = div_try >= {1'b0, nominal_freq_q};

	assign slope     = $signed({1'b0, volt_max_q}) - $signed({1'b0, volt_boost_q});
	assign slope_mag = slope[14] ? 14'(-slope) : slope[13:0];
	assign x_init    = 34'(volt_q * vfrg_pkg::CORDIC_SCALE);

	generate
		if (PHASE_BITS >= 32) begin : g_ph_wide
			assign ph32 = phase_q[PHASE_BITS-1 -: 32];
		end else begin : g_ph_narrow
			assign ph32 = {phase_q, {(32-PHASE_BITS){1'b0}}};
		end
	endgenerate

	assign ang = ph32 + 32'h2000_0000;
	assign xs  = x_q >>> cnt_q[4:0];
	assign ys  = y_q >>> cnt_q[4:0];

	// round, map back by quadrant and clamp to the amplitude
	always_comb begin
		xr   = 18'((x_q + 34'sd32768) >>> 16);
		yr   = 18'((y_q + 34'sd32768) >>> 16);
		vlim = $signed({4'd0, volt_q});
		case (quad_q)
			2'd0:    begin cval = xr;  sval = yr;  end
			2'd1:    begin cval = -yr; sval = xr;  end
			2'd2:    begin cval = -xr; sval = -yr; end
			default: begin cval = yr;  sval = -xr; end
		endcase
		if (cval > vlim) cval = vlim;
		else if (cval < -vlim) cval = -vlim;
		if (sval > vlim) sval = vlim;
		else if (sval < -vlim) sval = -vlim;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfrg_pkg::ST_IDLE:  if (in_xfer && tick) state_d = vfrg_pkg::ST_FREQ;
			vfrg_pkg::ST_FREQ:  state_d = vfrg_pkg::ST_PMUL;
			vfrg_pkg::ST_PMUL:  if (cnt_q == MUL_STEPS) state_d = vfrg_pkg::ST_VSEL;
			vfrg_pkg::ST_VSEL:  begin
				if (freq_q > nominal_freq_q || freq_q == 30'd0)
					state_d = vfrg_pkg::ST_CINIT;
				else
					state_d = vfrg_pkg::ST_VMUL;
			end
			vfrg_pkg::ST_VMUL:  if (cnt_q == MUL_STEPS) state_d = vfrg_pkg::ST_VDIV;
			vfrg_pkg::ST_VDIV:  if (cnt_q == DIV_STEPS) state_d = vfrg_pkg::ST_VOUT;
			vfrg_pkg::ST_VOUT:  state_d = vfrg_pkg::ST_CINIT;
			vfrg_pkg::ST_CINIT: state_d = vfrg_pkg::ST_CORD;
			vfrg_pkg::ST_CORD:  if (cnt_q == CORD_STEPS) state_d = vfrg_pkg::ST_DONE;
			vfrg_pkg::ST_DONE:  if (out_load) state_d = vfrg_pkg::ST_IDLE;
			default:            state_d = vfrg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfrg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_freq_q  <= 30'd100000000;
			ramp_step_q    <= 30'd833;
			nominal_freq_q <= 30'd50000000;
			volt_max_q     <= 14'd10000;
			volt_boost_q   <= 14'd1000;
			phase_gain_q   <= 40'd15372286728;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vfrg_pkg::REG_TARGET_FREQ:  target_freq_q  <= cfg_data[29:0];
				vfrg_pkg::REG_RAMP_STEP:    ramp_step_q    <= cfg_data[29:0];
				vfrg_pkg::REG_NOMINAL_FREQ: nominal_freq_q <= cfg_data[29:0];
				vfrg_pkg::REG_VOLT_MAX:     volt_max_q     <= cfg_data[13:0];
				vfrg_pkg::REG_VOLT_BOOST:   volt_boost_q   <= cfg_data[13:0];
				vfrg_pkg::REG_PHASE_GAIN:   phase_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q    <= '0;
			phase_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == vfrg_pkg::ST_FREQ)
				freq_q <= freq_next;
			if (state_q == vfrg_pkg::ST_PMUL && cnt_q == MUL_STEPS)
				phase_q <= phase_q + product[64-PHASE_BITS +: PHASE_BITS];
			if (out_load)
				out_valid <= 1'b1;
			else if (out_xfer)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vfrg_pkg::ST_IDLE: cnt_q <= '0;
			vfrg_pkg::ST_FREQ: begin
				// phase increment multiplier: frequency bits shift out LSB first
				mcand_q  <= phase_gain_q;
				mul_hi_q <= '0;
				mul_lo_q <= freq_next;
				cnt_q    <= '0;
			end
			vfrg_pkg::ST_PMUL, vfrg_pkg::ST_VMUL: begin
				if (cnt_q != MUL_STEPS) begin
					mul_hi_q <= {1'b0, mul_sum[40:1]};
					mul_lo_q <= {mul_sum[0], mul_lo_q[29:1]};
					cnt_q    <= cnt_q + 6'd1;
				end else begin
					cnt_q <= '0;
					dvd_q <= 45'(product[43:0]) + 45'(nominal_freq_q >> 1);
					rem_q <= '0;
				end
			end
			vfrg_pkg::ST_VSEL: begin
				cnt_q    <= '0;
				mcand_q  <= {10'd0, freq_q};
				mul_hi_q <= '0;
				mul_lo_q <= {16'd0, slope_mag};
				neg_q    <= slope[14];
				volt_q   <= (freq_q > nominal_freq_q) ? volt_max_q : volt_boost_q;
			end
			vfrg_pkg::ST_VDIV: begin
				if (cnt_q != DIV_STEPS) begin
					rem_q <= div_ge ? div_try - {1'b0, nominal_freq_q} : div_try;
					dvd_q <= {dvd_q[43:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
				end
			end
			vfrg_pkg::ST_VOUT:
				volt_q <= neg_q ? volt_boost_q - dvd_q[13:0] : volt_boost_q + dvd_q[13:0];
			vfrg_pkg::ST_CINIT: begin
				x_q    <= x_init;
				y_q    <= '0;
				z_q    <= $signed({3'd0, ang[29:0]}) - 33'sh2000_0000;
				quad_q <= ang[31:30];
				cnt_q  <= '0;
			end
			vfrg_pkg::ST_CORD: begin
				if (cnt_q != CORD_STEPS) begin
					cnt_q <= cnt_q + 6'd1;
					if (!z_q[32]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - $signed({3'd0, vfrg_pkg::ATAN_TABLE[cnt_q[4:0]]});
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + $signed({3'd0, vfrg_pkg::ATAN_TABLE[cnt_q[4:0]]});
					end
				end
			end
			vfrg_pkg::ST_DONE: begin
				if (out_load) begin
					out_freq    <= freq_q;
					out_voltage <= volt_q;
					out_phase   <= ph32;
					out_d       <= cval[14:0];
					out_q       <= sval[14:0];
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == vfrg_pkg::ST_DONE)
		else $error("result raised outside the final state");
	a_cord_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfrg_pkg::ST_CORD |-> cnt_q <= CORD_STEPS)
		else $error("CORDIC step count overran");
	a_freq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != vfrg_pkg::ST_FREQ |=> $stable(freq_q))
		else $error("frequency moved outside its update step");
	a_volt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (volt_q >= volt_boost_q && volt_q <= volt_max_q)
		|| (volt_q <= volt_boost_q && volt_q >= volt_max_q))
		else $error("voltage left the boost to max band");
`endif

endmodule
